// ----- rtl/core/lkv_pkg.sv -----
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int AGE_W   = IDX_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [AGE_W-1:0] age_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [ENTRIES-1:0][AGE_W-1:0] age_vec_t;
    typedef logic [ENTRIES-1:0] valid_vec_t;

    // Outcome of one pass over the store
    typedef struct packed {
        logic found;
        idx_t found_idx;
        idx_t lru_idx;
        idx_t lru2_idx;
        idx_t free_idx;
    } scan_res_t;

    // One write into the key and value memories
    typedef struct packed {
        logic key_en;
        logic val_en;
        idx_t addr;
        key_t key;
        val_t value;
    } store_wr_t;

endpackage

// ----- rtl/core/lkv_store.sv -----
module lkv_store (
    input  logic               aclk,
    input  lkv_pkg::idx_t      rd_addr,
    output lkv_pkg::key_t      rd_key,
    output lkv_pkg::val_t      rd_val,
    input  lkv_pkg::store_wr_t wr
);
    import lkv_pkg::*;

    key_t key_mem [ENTRIES];
    val_t val_mem [ENTRIES];
    key_t rd_key_reg;
    val_t rd_val_reg;

    always_ff @(posedge aclk) begin
        if (wr.key_en) begin
            key_mem[wr.addr] <= wr.key;
        end
        if (wr.val_en) begin
            val_mem[wr.addr] <= wr.value;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;

endmodule

// ----- rtl/core/lkv_scan.sv -----
module lkv_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  lkv_pkg::key_t       key,
    input  lkv_pkg::key_t       rd_key,
    input  lkv_pkg::valid_vec_t valid,
    input  lkv_pkg::age_vec_t   age,
    input  lkv_pkg::cnt_t       count,
    output lkv_pkg::idx_t       rd_addr,
    output logic                done,
    output lkv_pkg::scan_res_t  res
);
    import lkv_pkg::*;

    localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

    logic      active_reg, active_next;
    idx_t      issue_idx_reg, issue_idx_next;
    logic      cmp_vld_reg, cmp_vld_next;
    idx_t      cmp_idx_reg, cmp_idx_next;
    logic      done_reg, done_next;
    logic      free_ok_reg, free_ok_next;
    scan_res_t res_reg, res_next;
    cnt_t      age_ext;

    always_comb begin
        active_next    = active_reg;
        issue_idx_next = issue_idx_reg;
        cmp_vld_next   = active_reg;
        cmp_idx_next   = issue_idx_reg;
        done_next      = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
        free_ok_next   = free_ok_reg;
        res_next       = res_reg;
        age_ext        = {1'b0, age[cmp_idx_reg]};

        if (start) begin
            active_next    = 1'b1;
            issue_idx_next = '0;
            free_ok_next   = 1'b0;
            res_next.found = 1'b0;
        end else if (active_reg) begin
            issue_idx_next = issue_idx_reg + 1'b1;
            active_next    = (issue_idx_reg != LAST_IDX);
        end

        // Shared compare: one stored entry per cycle
        if (cmp_vld_reg) begin
            if (valid[cmp_idx_reg]) begin
                if (!res_reg.found && rd_key == key) begin
                    res_next.found     = 1'b1;
                    res_next.found_idx = cmp_idx_reg;
                end
                if (age_ext + 1'b1 == count) begin
                    res_next.lru_idx = cmp_idx_reg;
                end
                if (age_ext + CNT_W'(2) == count) begin
                    res_next.lru2_idx = cmp_idx_reg;
                end
            end else if (!free_ok_reg) begin
                free_ok_next      = 1'b1;
                res_next.free_idx = cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            issue_idx_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            done_reg      <= 1'b0;
            free_ok_reg   <= 1'b0;
            res_reg.found <= 1'b0;
        end else begin
            active_reg    <= active_next;
            issue_idx_reg <= issue_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            done_reg      <= done_next;
            free_ok_reg   <= free_ok_next;
            res_reg.found <= res_next.found;
        end
        res_reg.found_idx <= res_next.found_idx;
        res_reg.lru_idx   <= res_next.lru_idx;
        res_reg.lru2_idx  <= res_next.lru2_idx;
        res_reg.free_idx  <= res_next.free_idx;
    end

    assign rd_addr = issue_idx_reg;
    assign done    = done_reg;
    assign res     = res_reg;

endmodule

// ----- rtl/core/lru_key_value_cache_core.sv -----
// Sequence: the scan loop compares each stored entry in turn (16 entries, one key memory
//   read each), then the matched value is read and the update presents the result.
// One item at a time: s_tready is high only in idle; the update waits on m_tready.
// Reset: synchronous, active-low aresetn clears all valid bits, ages, the entry count and
//   the output register, and sets capacity to 16; key and value memories are not cleared.
module lru_key_value_cache_core (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // input channel
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]  s_tdata,  // key[31:0], value[63:32]
    input  logic                                      s_tuser,  // kind (0 get, 1 put)
    // result channel
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [lkv_pkg::VAL_W-1:0]                 m_tdata,  // read_value[31:0]
    output logic                                      m_tuser,  // hit
    // capacity register
    input  logic                                      cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]                 cfg_wr_data
);
    import lkv_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic             kind_reg;
    key_t             key_reg;
    val_t             val_reg;
    valid_vec_t       valid_reg, valid_next;
    age_vec_t         age_reg, age_next;
    cnt_t             cnt_reg, cnt_next;
    logic             m_valid_reg;
    logic             m_hit_reg;
    val_t             m_data_reg;

    logic      accept;
    logic      scan_done;
    idx_t      scan_addr;
    idx_t      rd_addr;
    key_t      rd_key;
    val_t      rd_val;
    scan_res_t res;
    store_wr_t wr;

    logic      out_free;
    logic      upd_fire;
    cnt_t      eff_cap;
    age_t      touch_age;
    logic      do_touch;
    logic      do_inc_all;
    logic      do_insert;
    logic      do_evict;
    idx_t      ins_idx;
    idx_t      ev_idx;
    logic      put_hit;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign upd_fire = (state_reg == S_UPDATE) && out_free;

    // Read the matched entry's value after the scan and hold it while the update waits;
    // otherwise follow the scan pointer
    assign rd_addr = (state_reg == S_READ || state_reg == S_UPDATE) ? res.found_idx
                                                                    : scan_addr;

    lkv_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (key_reg),
        .rd_key  (rd_key),
        .valid   (valid_reg),
        .age     (age_reg),
        .count   (cnt_reg),
        .rd_addr (scan_addr),
        .done    (scan_done),
        .res     (res)
    );

    lkv_store u_store (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .wr      (wr)
    );

    // Clamp capacity into 1..ENTRIES
    always_comb begin
        priority if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (CNT_W'(cap_reg) > CNT_W'(ENTRIES)) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // Decide what this item does to the recency state
    always_comb begin
        touch_age  = age_reg[res.found_idx];
        put_hit    = (kind_reg == KIND_PUT) && res.found;
        do_touch   = res.found;
        do_inc_all = 1'b0;
        do_insert  = 1'b0;
        do_evict   = 1'b0;
        ins_idx    = res.free_idx;
        ev_idx     = res.lru_idx;
        cnt_next   = cnt_reg;

        if (kind_reg == KIND_PUT && res.found) begin
            // A touched LRU entry hands the LRU role to the next oldest
            if (cnt_reg > eff_cap) begin
                do_evict = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if ({1'b0, touch_age} + 1'b1 == cnt_reg) begin
                    ev_idx = res.lru2_idx;
                end
            end
        end else if (kind_reg == KIND_PUT) begin
            do_inc_all = 1'b1;
            do_insert  = 1'b1;
            if (cnt_reg == CNT_W'(ENTRIES)) begin
                // Full store: replace the LRU entry in place
                ins_idx = res.lru_idx;
            end else if (cnt_reg + 1'b1 > eff_cap) begin
                do_evict = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        age_next   = age_reg;
        for (int j = 0; j < ENTRIES; j++) begin
            if (do_touch && valid_reg[j] && age_reg[j] < touch_age) begin
                age_next[j] = age_reg[j] + 1'b1;
            end
            if (do_inc_all && valid_reg[j]) begin
                age_next[j] = age_reg[j] + 1'b1;
            end
            if (do_insert && IDX_W'(j) == ins_idx) begin
                age_next[j]   = '0;
                valid_next[j] = 1'b1;
            end
            if (do_touch && IDX_W'(j) == res.found_idx) begin
                age_next[j] = '0;
            end
            if (do_evict && IDX_W'(j) == ev_idx) begin
                age_next[j]   = '0;
                valid_next[j] = 1'b0;
            end
        end
    end

    always_comb begin
        wr.key_en = upd_fire && do_insert;
        wr.val_en = upd_fire && (do_insert || put_hit);
        wr.addr   = put_hit ? res.found_idx : ins_idx;
        wr.key    = key_reg;
        wr.value  = val_reg;
    end

    // Sequencer: scan, fetch the matched value, then update and present the result
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_W'(ENTRIES);
            valid_reg   <= '0;
            age_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (upd_fire) begin
                valid_reg   <= valid_next;
                age_reg     <= age_next;
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: latch the transaction and the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            val_reg  <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (upd_fire) begin
            m_hit_reg <= res.found;
            if (kind_reg == KIND_PUT) begin
                m_data_reg <= val_reg;
            end else if (res.found) begin
                m_data_reg <= rd_val;
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

endmodule
